FILE: hw/rtl/nearest_neighbor_rgb_resize_defines.svh
// Assertion helpers, included by nnrr_ctrl.sv.
`ifndef NEAREST_NEIGHBOR_RGB_RESIZE_DEFINES_SVH
`define NEAREST_NEIGHBOR_RGB_RESIZE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NNRR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NNRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/nnrr_pkg.sv
package nnrr_pkg;

   localparam int NNRR_MAX_DIM      = 512;
   localparam int NNRR_STORE_PIXELS = 262144;

   localparam int DIM_W     = 10;
   localparam int POS_W     = 9;
   localparam int COLOR_W   = 8;
   localparam int PIX_W     = 3 * COLOR_W;
   localparam int PROD_W    = POS_W + DIM_W;
   localparam int IDX_W     = 2 * DIM_W;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

   localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = 10'd320;
   localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = 10'd240;
   localparam logic [DIM_W-1:0] DST_WIDTH_RST  = 10'd160;
   localparam logic [DIM_W-1:0] DST_HEIGHT_RST = 10'd120;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } nnrr_op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_WR_DROP  = 2'd1,
      STATUS_RD_RANGE = 2'd2
   } nnrr_status_type;

   typedef struct packed {
      logic load_req;
      logic do_write;
      logic check;
      logic row_start;
      logic row_save;
      logic col_start;
      logic col_save;
      logic calc_index;
      logic lookup;
      logic load_rsp;
   } nnrr_cmd_type;

   typedef struct packed {
      logic out_of_range;
      logic div_busy;
      logic div_done;
   } nnrr_stat_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input int max_dim);
      logic [DIM_W-1:0] res;
      res = value;
      if (int'(value) > max_dim) begin
         res = DIM_W'(max_dim);
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/nnrr_if.sv
interface nnrr_req_if;
   import nnrr_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic               frame_start;
   logic [COLOR_W-1:0] in_red;
   logic [COLOR_W-1:0] in_green;
   logic [COLOR_W-1:0] in_blue;
   logic [POS_W-1:0]   dst_row;
   logic [POS_W-1:0]   dst_col;

   modport source (output valid, cmd, frame_start, in_red, in_green, in_blue,
                   dst_row, dst_col, input ready);
   modport sink (input valid, cmd, frame_start, in_red, in_green, in_blue,
                 dst_row, dst_col, output ready);
endinterface

interface nnrr_rsp_if;
   import nnrr_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] out_red;
   logic [COLOR_W-1:0] out_green;
   logic [COLOR_W-1:0] out_blue;
   logic [1:0]         status;

   modport source (output valid, out_red, out_green, out_blue, status, input ready);
   modport sink (input valid, out_red, out_green, out_blue, status, output ready);
endinterface

FILE: hw/rtl/nearest_neighbor_rgb_resize.sv
// Nearest-neighbor RGB scaler over an on-chip frame store.
// req_chan carries one request: cmd 0 writes a source pixel at the running raster
// address (frame_start restarts it at zero), cmd 1 reads destination (dst_row, dst_col),
// mapped to source row dst_row*src_h/dst_h and column dst_col*src_w/dst_w.
// rsp_chan returns one result per request: the pixel bytes and a status
// (0 ok, 1 write dropped past the frame, 2 read outside the destination or store).
// csr_we/csr_index/csr_wdata set src width, src height, dst width, dst height
// (indexes 0..3); write them only while no request is in flight.
// Sequence: a write steps through WRITE then RESULT; an in-range read through CHECK,
// the row division, the column division, INDEX, LOOKUP and RESULT; an outside read from CHECK to RESULT.
// One request at a time: a new one is accepted the cycle after the result
// is loaded, and none while one is being worked on. An in-range read runs
// two 10-step divisions on the single shared divider, one quotient bit per cycle.
// Reset clears the write address, the control state and loads the default sizes
// (320x240 source, 160x120 destination); the frame store itself is not cleared.
// When rsp ready is low the finished result waits in the output register and the next
// request is still taken; its result waits in turn until the register frees up.
module nearest_neighbor_rgb_resize #(
   parameter int MAX_DIM      = nnrr_pkg::NNRR_MAX_DIM,
   parameter int STORE_PIXELS = nnrr_pkg::NNRR_STORE_PIXELS
) (
   input  logic                           clock,
   input  logic                           reset,
   nnrr_req_if.sink                       req_chan,
   nnrr_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [nnrr_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [nnrr_pkg::DIM_W-1:0]     csr_wdata
);
   import nnrr_pkg::*;

   nnrr_cmd_type  cmd;
   nnrr_stat_type stat;

   nnrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (nnrr_op_type'(req_chan.cmd)),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   nnrr_dp #(
      .MAX_DIM      (MAX_DIM),
      .STORE_PIXELS (STORE_PIXELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_chan.cmd),
      .req_frame_start (req_chan.frame_start),
      .req_red         (req_chan.in_red),
      .req_green       (req_chan.in_green),
      .req_blue        (req_chan.in_blue),
      .req_row         (req_chan.dst_row),
      .req_col         (req_chan.dst_col),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_red         (rsp_chan.out_red),
      .rsp_green       (rsp_chan.out_green),
      .rsp_blue        (rsp_chan.out_blue),
      .rsp_status      (rsp_chan.status)
   );

endmodule

FILE: hw/rtl/nnrr_div.sv
module nnrr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [nnrr_pkg::PROD_W-1:0] dividend,
   input  logic [nnrr_pkg::DIM_W-1:0]  divisor,
   output logic                        busy,
   output logic                        done,
   output logic [nnrr_pkg::DIM_W-1:0]  quotient
);
   import nnrr_pkg::*;

   localparam int STEPS = DIM_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [DIM_W-1:0] rem_ff, rem_in;
   logic [DIM_W-1:0] low_ff, low_in;
   logic [DIM_W-1:0] divisor_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DIM_W:0]   trial;
   logic             fits;

   // Restoring division, one quotient bit a cycle. The caller guarantees the
   // quotient fits in DIM_W bits, so the upper dividend bits start as remainder.
   always_comb begin
      trial  = {rem_ff, low_ff[DIM_W-1]};
      fits   = trial >= {1'b0, divisor_ff};
      rem_in = fits ? DIM_W'(trial - {1'b0, divisor_ff}) : trial[DIM_W-1:0];
      low_in = {low_ff[DIM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(STEPS - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= DIM_W'(dividend[PROD_W-1:DIM_W]);
         low_ff     <= dividend[DIM_W-1:0];
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

FILE: hw/rtl/nnrr_dp.sv
module nnrr_dp #(
   parameter int MAX_DIM      = nnrr_pkg::NNRR_MAX_DIM,
   parameter int STORE_PIXELS = nnrr_pkg::NNRR_STORE_PIXELS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [nnrr_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [nnrr_pkg::DIM_W-1:0]     csr_wdata,
   input  logic                           req_cmd,
   input  logic                           req_frame_start,
   input  logic [nnrr_pkg::COLOR_W-1:0]   req_red,
   input  logic [nnrr_pkg::COLOR_W-1:0]   req_green,
   input  logic [nnrr_pkg::COLOR_W-1:0]   req_blue,
   input  logic [nnrr_pkg::POS_W-1:0]     req_row,
   input  logic [nnrr_pkg::POS_W-1:0]     req_col,
   input  nnrr_pkg::nnrr_cmd_type         cmd,
   output nnrr_pkg::nnrr_stat_type        stat,
   output logic [nnrr_pkg::COLOR_W-1:0]   rsp_red,
   output logic [nnrr_pkg::COLOR_W-1:0]   rsp_green,
   output logic [nnrr_pkg::COLOR_W-1:0]   rsp_blue,
   output logic [1:0]                     rsp_status
);
   import nnrr_pkg::*;

   localparam int ADDR_W = $clog2(STORE_PIXELS);
   localparam int WA_FULL_W = $clog2(STORE_PIXELS + 1);
   localparam int WA_W = (WA_FULL_W < IDX_W) ? WA_FULL_W : IDX_W;

   logic [DIM_W-1:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [IDX_W-1:0] area_ff;

   nnrr_op_type        op_ff;
   logic               fs_ff;
   logic [PIX_W-1:0]   rgb_ff;
   logic [POS_W-1:0]   row_ff, col_ff;

   logic [WA_W-1:0]    wa_ff, wa_in, wa_cur;
   logic [31:0]        wa_ext;
   logic               wr_ok;

   logic [PROD_W-1:0]  prod_ff;
   logic [DIM_W-1:0]   srow_ff, scol_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [31:0]        idx_ext;
   logic               idx_ok;
   nnrr_status_type    status_ff;

   logic [PIX_W-1:0]   mem [STORE_PIXELS];
   logic [PIX_W-1:0]   rdata_ff;

   logic [COLOR_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [1:0]         rsp_status_ff;

   logic               div_start;
   logic [DIM_W-1:0]   div_divisor;
   logic               div_busy, div_done;
   logic [DIM_W-1:0]   div_quot;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= clamp_dim(SRC_WIDTH_RST, MAX_DIM);
         src_h_ff <= clamp_dim(SRC_HEIGHT_RST, MAX_DIM);
         dst_w_ff <= clamp_dim(DST_WIDTH_RST, MAX_DIM);
         dst_h_ff <= clamp_dim(DST_HEIGHT_RST, MAX_DIM);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SRC_WIDTH:  src_w_ff <= clamp_dim(csr_wdata, MAX_DIM);
            REG_SRC_HEIGHT: src_h_ff <= clamp_dim(csr_wdata, MAX_DIM);
            REG_DST_WIDTH:  dst_w_ff <= clamp_dim(csr_wdata, MAX_DIM);
            REG_DST_HEIGHT: dst_h_ff <= clamp_dim(csr_wdata, MAX_DIM);
            default: ;
         endcase
      end
   end

   // Source area is a registered product of the size registers.
   always_ff @(posedge clock) begin
      area_ff <= IDX_W'(src_w_ff) * IDX_W'(src_h_ff);
   end

   // Write address, saturating at the end of the frame
   always_comb begin
      wa_cur = fs_ff ? '0 : wa_ff;
      wa_ext = 32'(wa_cur);
      wr_ok  = (wa_ext < 32'(area_ff)) && (wa_ext < 32'(STORE_PIXELS));
      wa_in  = wr_ok ? WA_W'(wa_cur + 1'b1) : wa_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wa_ff <= '0;
      end else if (cmd.do_write) begin
         wa_ff <= wa_in;
      end
   end

   always_comb begin
      idx_ext = 32'(idx_ff);
      idx_ok  = (idx_ext < 32'(area_ff)) && (idx_ext < 32'(STORE_PIXELS));
   end

   assign stat.out_of_range = ({1'b0, row_ff} >= dst_h_ff) || ({1'b0, col_ff} >= dst_w_ff);
   assign stat.div_busy     = div_busy;
   assign stat.div_done     = div_done;

   assign div_start   = cmd.row_start || cmd.col_start;
   assign div_divisor = cmd.col_start ? dst_w_ff : dst_h_ff;

   nnrr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= nnrr_op_type'(req_cmd);
         fs_ff  <= req_frame_start;
         rgb_ff <= {req_red, req_green, req_blue};
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (cmd.do_write) begin
         status_ff <= wr_ok ? STATUS_OK : STATUS_WR_DROP;
      end
      if (cmd.check) begin
         status_ff <= stat.out_of_range ? STATUS_RD_RANGE : STATUS_OK;
         prod_ff   <= PROD_W'(row_ff) * PROD_W'(src_h_ff);
      end
      if (cmd.row_save) begin
         srow_ff <= div_quot;
         prod_ff <= PROD_W'(col_ff) * PROD_W'(src_w_ff);
      end
      if (cmd.col_save) begin
         scol_ff <= div_quot;
      end
      if (cmd.calc_index) begin
         idx_ff <= IDX_W'(srow_ff) * IDX_W'(src_w_ff) + IDX_W'(scol_ff);
      end
      if (cmd.lookup) begin
         status_ff <= idx_ok ? STATUS_OK : STATUS_RD_RANGE;
      end
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.do_write && wr_ok) begin
         mem[wa_ext[ADDR_W-1:0]] <= rgb_ff;
      end
      if (cmd.lookup && idx_ok) begin
         rdata_ff <= mem[idx_ext[ADDR_W-1:0]];
      end
   end

   // Result register; colors are zero unless a read found its pixel.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (op_ff == OP_READ && status_ff == STATUS_OK) begin
            rsp_red_ff   <= rdata_ff[PIX_W-1 -: COLOR_W];
            rsp_green_ff <= rdata_ff[COLOR_W +: COLOR_W];
            rsp_blue_ff  <= rdata_ff[COLOR_W-1:0];
         end else begin
            rsp_red_ff   <= '0;
            rsp_green_ff <= '0;
            rsp_blue_ff  <= '0;
         end
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_red    = rsp_red_ff;
   assign rsp_green  = rsp_green_ff;
   assign rsp_blue   = rsp_blue_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: hw/rtl/nnrr_ctrl.sv
`include "nearest_neighbor_rgb_resize_defines.svh"

module nnrr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  nnrr_pkg::nnrr_op_type   req_op,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output nnrr_pkg::nnrr_cmd_type  cmd,
   input  nnrr_pkg::nnrr_stat_type stat
);
   import nnrr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_CHECK,
      ST_ROW_START,
      ST_ROW_WAIT,
      ST_COL_START,
      ST_COL_WAIT,
      ST_INDEX,
      ST_LOOKUP,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_op == OP_READ) ? ST_CHECK : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.do_write = 1'b1;
            state_in     = ST_RESULT;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.out_of_range ? ST_RESULT : ST_ROW_START;
         end
         ST_ROW_START: begin
            cmd.row_start = 1'b1;
            state_in      = ST_ROW_WAIT;
         end
         ST_ROW_WAIT: begin
            if (stat.div_done) begin
               cmd.row_save = 1'b1;
               state_in     = ST_COL_START;
            end
         end
         ST_COL_START: begin
            cmd.col_start = 1'b1;
            state_in      = ST_COL_WAIT;
         end
         ST_COL_WAIT: begin
            if (stat.div_done) begin
               cmd.col_save = 1'b1;
               state_in     = ST_INDEX;
            end
         end
         ST_INDEX: begin
            cmd.calc_index = 1'b1;
            state_in       = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `NNRR_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `NNRR_ASSERT_NOW(a_load_into_free, clock, reset, cmd.load_rsp, slot_free, "result overwrites an untaken result")
   `NNRR_ASSERT_NOW(a_div_start_idle, clock, reset, cmd.row_start || cmd.col_start, !stat.div_busy, "divider started while busy")

endmodule
